// ===== hdl/ppt_pkg.sv =====
package ppt_pkg;

    localparam int PATH_DEPTH   = 256;
    localparam int IDX_W        = $clog2(PATH_DEPTH);
    localparam int CNT_W        = IDX_W + 1;

    localparam int WRAP_LIMIT   = 12861;
    localparam int WRAP_STEP    = 25723;
    localparam int STEER_LIMIT  = 4096;
    localparam int HALF_PI_Q20  = 1647099;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_W     = 45;
    localparam int ANG_W        = 25;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;

    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_point;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic [20:0] atan_q20(input logic [4:0] i);
        logic [20:0] v;
        case (i)
            5'd0:    v = 21'd823550;
            5'd1:    v = 21'd486170;
            5'd2:    v = 21'd256879;
            5'd3:    v = 21'd130396;
            5'd4:    v = 21'd65451;
            5'd5:    v = 21'd32757;
            5'd6:    v = 21'd16383;
            5'd7:    v = 21'd8192;
            5'd8:    v = 21'd4096;
            5'd9:    v = 21'd2048;
            5'd10:   v = 21'd1024;
            5'd11:   v = 21'd512;
            5'd12:   v = 21'd256;
            5'd13:   v = 21'd128;
            5'd14:   v = 21'd64;
            5'd15:   v = 21'd32;
            5'd16:   v = 21'd16;
            5'd17:   v = 21'd8;
            5'd18:   v = 21'd4;
            5'd19:   v = 21'd2;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ppt_path_mem.sv =====
module ppt_path_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ppt_pkg::IDX_W-1:0]  i_wr_addr,
    input  ppt_pkg::t_point            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ppt_pkg::IDX_W-1:0]  i_rd_addr,
    output ppt_pkg::t_point            o_rd_data
);

    ppt_pkg::t_point r_mem [ppt_pkg::PATH_DEPTH];
    ppt_pkg::t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ppt_isqrt.sv =====
module ppt_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [64:0]        i_value,
    output ppt_pkg::t_unit_sts o_sts,
    output logic [32:0]        o_root
);

    localparam logic [5:0] LAST_STEP = 6'd32;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [65:0] r_val;
    logic [35:0] r_rem;
    logic [32:0] r_root;
    logic [35:0] n_shift;
    logic [35:0] n_trial;
    logic        n_ge;

    always_comb begin
        n_shift = {r_rem[33:0], r_val[65:64]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = (n_shift >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= {1'b0, i_value};
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? (n_shift - n_trial) : n_shift;
                r_root <= {r_root[31:0], n_ge};
                r_val  <= {r_val[63:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

// ===== hdl/ppt_cordic.sv =====
module ppt_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_x,
    input  logic signed [32:0] i_y,
    output ppt_pkg::t_unit_sts o_sts,
    output logic signed [16:0] o_angle
);

    localparam int W = ppt_pkg::CORDIC_W;
    localparam int A = ppt_pkg::ANG_W;
    localparam logic [W-1:0] NORM_LIMIT = W'(1) << 40;
    localparam logic [4:0]   LAST_ITER  = 5'(ppt_pkg::CORDIC_STEPS - 1);
    localparam logic signed [A-1:0] HALF_PI = A'(ppt_pkg::HALF_PI_Q20);

    typedef enum logic [1:0] {S_IDLE, S_NORM, S_ITER} t_state;

    t_state              r_state;
    logic                r_done;
    logic [4:0]          r_i;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [A-1:0] r_ang;
    logic signed [16:0]  r_angle;

    logic signed [W-1:0] n_xe;
    logic signed [W-1:0] n_ye;
    logic signed [W-1:0] n_sx;
    logic signed [W-1:0] n_sy;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic signed [A-1:0] n_step;
    logic signed [A-1:0] n_ang;
    logic signed [A-1:0] n_round;
    logic [W-1:0]        n_mx;
    logic [W-1:0]        n_my;

    always_comb begin
        n_xe    = {{(W-33){i_x[32]}}, i_x};
        n_ye    = {{(W-33){i_y[32]}}, i_y};
        n_mx    = r_x[W-1] ? W'(-r_x) : W'(r_x);
        n_my    = r_y[W-1] ? W'(-r_y) : W'(r_y);
        n_sx    = r_x >>> r_i;
        n_sy    = r_y >>> r_i;
        n_step  = {{(A-21){1'b0}}, ppt_pkg::atan_q20(r_i)};
        if (r_y > 0) begin
            n_x   = r_x + n_sy;
            n_y   = r_y - n_sx;
            n_ang = r_ang + n_step;
        end else begin
            n_x   = r_x - n_sy;
            n_y   = r_y + n_sx;
            n_ang = r_ang - n_step;
        end
        n_round = (n_ang + A'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_x == 0 && i_y == 0) begin
                            r_angle <= '0;
                            r_done  <= 1'b1;
                        end else begin
                            if (i_x < 0) begin
                                if (i_y >= 0) begin
                                    r_x   <= n_ye;
                                    r_y   <= -n_xe;
                                    r_ang <= HALF_PI;
                                end else begin
                                    r_x   <= -n_ye;
                                    r_y   <= n_xe;
                                    r_ang <= -HALF_PI;
                                end
                            end else begin
                                r_x   <= n_xe;
                                r_y   <= n_ye;
                                r_ang <= '0;
                            end
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (n_mx < NORM_LIMIT && n_my < NORM_LIMIT) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_ang <= n_ang;
                    r_i   <= r_i + 5'd1;
                    if (r_i == LAST_ITER) begin
                        r_angle <= 17'(n_round);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done;
    assign o_angle    = r_angle;

endmodule

// ===== hdl/ppt_div.sv =====
module ppt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [27:0]        i_num,
    input  logic [16:0]        i_den,
    output ppt_pkg::t_unit_sts o_sts,
    output logic [15:0]        o_quot
);

    localparam logic [4:0] LAST_STEP = 5'd27;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [17:0] r_rem;
    logic [27:0] r_q;
    logic [16:0] r_den;
    logic [15:0] r_quot;
    logic [17:0] n_shift;
    logic        n_ge;
    logic [27:0] n_q;

    always_comb begin
        n_shift = {r_rem[16:0], r_q[27]};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_q     = {r_q[26:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_shift - {1'b0, r_den}) : n_shift;
                r_q   <= n_q;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_quot <= (n_q[27:16] != 12'd0) ? 16'hFFFF : n_q[15:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== hdl/pure_pursuit_tracker.sv =====
// channel   | direction | payload
// s_axis    | in        | load point or pose query
// m_axis    | out       | one result item per query
// apb       | in/out    | lookahead gain, lookahead base, cruise speed
//
// A query runs the nearest-point scan through the single read port of the path memory,
// a bit-serial root for each walked segment, the goal read and angle (normalizing
// shifts and iterations, both skipped when goal and vehicle coincide) and the speed
// divide, which is skipped at zero heading error.
// Reset clears path count and goal; the path memory itself is not cleared.
// A finished result waits in the output register; the next item is accepted meanwhile.
module pure_pursuit_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // pos_x, pos_y, yaw, speed, zero pad
    input  logic [1:0]  s_axis_tuser,  // req_type, first_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // goal_index, heading_error, steer_cmd, speed_cmd, pad
    output logic [0:0]  m_axis_tuser,  // no_path
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = ppt_pkg::IDX_W;
    localparam int CW = ppt_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH = CW'(ppt_pkg::PATH_DEPTH);
    localparam logic signed [17:0] WLIM  = 18'(ppt_pkg::WRAP_LIMIT);
    localparam logic signed [17:0] WSTEP = 18'(ppt_pkg::WRAP_STEP);
    localparam logic signed [17:0] SLIM  = 18'(ppt_pkg::STEER_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE, S_SC_RD, S_SC_MAG, S_SC_SQ, S_SC_CMP,
        S_WK_CHK, S_WK_MAG, S_WK_SQ, S_WK_SUM, S_WK_RT,
        S_GL_RD, S_GL_DAT, S_CORD, S_ALPHA, S_DIV, S_DONE
    } t_state;

    t_state             r_state;
    logic [15:0]        r_gain;
    logic [23:0]        r_base;
    logic [15:0]        r_target;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_last;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [14:0] r_yaw;
    logic [32:0]        r_lf;
    ppt_pkg::t_point    r_b;
    ppt_pkg::t_point    r_c;
    ppt_pkg::t_point    r_bpt;
    logic [31:0]        r_mx;
    logic [31:0]        r_my;
    logic [63:0]        r_sx;
    logic [63:0]        r_sy;
    logic [64:0]        r_best;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_idx;
    logic [33:0]        r_walked;
    logic signed [17:0] r_alpha;
    logic [7:0]         r_res_idx;
    logic [14:0]        r_res_alpha;
    logic [13:0]        r_res_steer;
    logic [15:0]        r_res_speed;
    logic               r_res_nopath;
    logic               r_out_valid;
    logic [55:0]        r_out_data;
    logic               r_out_user;
    logic               r_sqrt_start;
    logic               r_cord_start;
    logic               r_div_start;
    logic signed [32:0] r_cx;
    logic signed [32:0] r_cy;
    logic [16:0]        r_abs;

    ppt_pkg::t_point    mem_rd_data;
    ppt_pkg::t_point    mem_wr_data;
    logic               mem_we;
    logic               mem_re;
    logic [IW-1:0]      mem_wr_addr;
    logic [IW-1:0]      mem_rd_addr;

    ppt_pkg::t_unit_sts sqrt_sts;
    ppt_pkg::t_unit_sts cord_sts;
    ppt_pkg::t_unit_sts div_sts;
    logic [32:0]        sqrt_root;
    logic signed [16:0] cord_angle;
    logic [15:0]        div_quot;

    logic               n_accept;
    logic               n_query;
    logic [CW-1:0]      n_eff;
    logic               n_walk_go;
    logic signed [32:0] n_dx;
    logic signed [32:0] n_dy;
    logic [64:0]        n_d2;
    logic               n_upd;
    logic [IW-1:0]      n_goal;
    logic [IW-1:0]      n_goal_c;
    logic signed [17:0] n_a0;
    logic signed [17:0] n_a1;
    logic signed [17:0] n_a2;
    logic signed [17:0] n_steer;
    logic               n_out_load;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign n_accept      = s_axis_tvalid && s_axis_tready;
    assign n_query       = s_axis_tuser[0];

    always_comb begin
        n_eff     = s_axis_tuser[1] ? '0 : r_count;
        n_walk_go = (r_walked < {1'b0, r_lf}) && (({1'b0, r_idx} + CW'(1)) < r_count);
        n_dx      = {mem_rd_data.x[31], mem_rd_data.x} - {r_b.x[31], r_b.x};
        n_dy      = {mem_rd_data.y[31], mem_rd_data.y} - {r_b.y[31], r_b.y};
        n_d2      = {1'b0, r_sx} + {1'b0, r_sy};
        n_upd     = (r_i == '0) || (n_d2 < r_best);
        n_goal    = (r_idx < r_last) ? r_last : r_idx;
        n_goal_c  = ({1'b0, n_goal} > (r_count - CW'(1))) ? IW'(r_count - CW'(1)) : n_goal;
        n_a0      = {cord_angle[16], cord_angle} - {{3{r_yaw[14]}}, r_yaw};
        n_a1      = (n_a0 < -WLIM) ? (n_a0 + WSTEP) : n_a0;
        n_a2      = (n_a1 > WLIM) ? (n_a1 - WSTEP) : n_a1;
        if (r_alpha > SLIM) begin
            n_steer = SLIM;
        end else if (r_alpha < -SLIM) begin
            n_steer = -SLIM;
        end else begin
            n_steer = r_alpha;
        end
        n_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_comb begin
        mem_we      = n_accept && !n_query && (n_eff < DEPTH);
        mem_wr_addr = IW'(n_eff);
        mem_wr_data = {s_axis_tdata[63:32], s_axis_tdata[31:0]};
        mem_re      = (r_state == S_SC_RD) || (r_state == S_GL_RD)
                   || ((r_state == S_WK_CHK) && n_walk_go);
        case (r_state)
            S_SC_RD:  mem_rd_addr = r_i;
            S_WK_CHK: mem_rd_addr = r_idx + IW'(1);
            default:  mem_rd_addr = r_idx;
        endcase
    end

    always_comb begin
        unique case (paddr[3:2])
            ppt_pkg::REG_GAIN:   prdata = {16'd0, r_gain};
            ppt_pkg::REG_BASE:   prdata = {8'd0, r_base};
            ppt_pkg::REG_TARGET: prdata = {16'd0, r_target};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 16'd256;
            r_base   <= 24'd65536;
            r_target <= 16'd256;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                ppt_pkg::REG_GAIN:   r_gain   <= pwdata[15:0];
                ppt_pkg::REG_BASE:   r_base   <= pwdata[23:0];
                ppt_pkg::REG_TARGET: r_target <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_cord_start <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_sqrt_start <= 1'b0;
            r_cord_start <= 1'b0;
            r_div_start  <= 1'b0;
            if (m_axis_tvalid && m_axis_tready && !n_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (!n_query) begin
                            if (s_axis_tuser[1]) begin
                                r_last <= '0;
                            end
                            r_count <= (n_eff < DEPTH) ? (n_eff + CW'(1)) : n_eff;
                        end else if (r_count == '0) begin
                            r_res_idx    <= '0;
                            r_res_alpha  <= '0;
                            r_res_steer  <= '0;
                            r_res_speed  <= '0;
                            r_res_nopath <= 1'b1;
                            r_state      <= S_DONE;
                        end else begin
                            r_px  <= s_axis_tdata[31:0];
                            r_py  <= s_axis_tdata[63:32];
                            r_yaw <= s_axis_tdata[78:64];
                            r_b   <= {s_axis_tdata[63:32], s_axis_tdata[31:0]};
                            r_lf  <= {1'b0, {16'd0, r_gain} * {16'd0, s_axis_tdata[94:79]}}
                                   + {9'd0, r_base};
                            r_i   <= '0;
                            r_idx <= '0;
                            r_res_nopath <= 1'b0;
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_SC_RD: r_state <= S_SC_MAG;
                S_SC_MAG, S_WK_MAG: begin
                    r_c  <= mem_rd_data;
                    r_mx <= 32'(n_dx[32] ? -n_dx : n_dx);
                    r_my <= 32'(n_dy[32] ? -n_dy : n_dy);
                    r_state <= (r_state == S_SC_MAG) ? S_SC_SQ : S_WK_SQ;
                end
                S_SC_SQ, S_WK_SQ: begin
                    r_sx <= r_mx * r_mx;
                    r_sy <= r_my * r_my;
                    r_state <= (r_state == S_SC_SQ) ? S_SC_CMP : S_WK_SUM;
                end
                S_SC_CMP: begin
                    if (n_upd) begin
                        r_best <= n_d2;
                        r_bpt  <= r_c;
                        r_idx  <= r_i;
                    end
                    if ({1'b0, r_i} == (r_count - CW'(1))) begin
                        r_b      <= n_upd ? r_c : r_bpt;
                        r_walked <= '0;
                        r_state  <= S_WK_CHK;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_WK_CHK: begin
                    if (n_walk_go) begin
                        r_state <= S_WK_MAG;
                    end else begin
                        r_idx   <= n_goal_c;
                        r_last  <= n_goal_c;
                        r_state <= S_GL_RD;
                    end
                end
                S_WK_SUM: begin
                    r_sqrt_start <= 1'b1;
                    r_state      <= S_WK_RT;
                end
                S_WK_RT: begin
                    if (sqrt_sts.done) begin
                        r_walked <= r_walked + 34'(sqrt_root);
                        r_idx    <= r_idx + IW'(1);
                        r_b      <= r_c;
                        r_state  <= S_WK_CHK;
                    end
                end
                S_GL_RD: r_state <= S_GL_DAT;
                S_GL_DAT: begin
                    r_cx <= {mem_rd_data.x[31], mem_rd_data.x} - {r_px[31], r_px};
                    r_cy <= {mem_rd_data.y[31], mem_rd_data.y} - {r_py[31], r_py};
                    r_cord_start <= 1'b1;
                    r_state      <= S_CORD;
                end
                S_CORD: begin
                    if (cord_sts.done) begin
                        r_alpha <= n_a2;
                        r_state <= S_ALPHA;
                    end
                end
                S_ALPHA: begin
                    r_res_idx   <= 8'(r_idx);
                    r_res_alpha <= 15'(r_alpha);
                    r_res_steer <= 14'(n_steer);
                    r_abs       <= 17'(r_alpha[17] ? -r_alpha : r_alpha);
                    if (r_alpha == '0) begin
                        r_res_speed <= 16'hFFFF;
                        r_state     <= S_DONE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        r_res_speed <= div_quot;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'd0, r_res_speed, r_res_steer, r_res_alpha, r_res_idx};
                        r_out_user  <= r_res_nopath;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    ppt_path_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    ppt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_value (n_d2),
        .o_sts   (sqrt_sts),
        .o_root  (sqrt_root)
    );

    ppt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cord_start),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .o_sts   (cord_sts),
        .o_angle (cord_angle)
    );

    ppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   ({r_target, 12'd0}),
        .i_den   (r_abs),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

`ifndef SYNTHESIS
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re)
        else $error("path memory written and read in one cycle");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!sqrt_sts.busy && !cord_sts.busy && !div_sts.busy))
        else $error("item accepted while an arithmetic unit is busy");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WK_CHK) |-> ({1'b0, r_idx} < r_count))
        else $error("walk index beyond stored path");
`endif

endmodule

// ===== dv/pure_pursuit_tracker_checker.sv =====
module pure_pursuit_tracker_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, yaw, speed, zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type, first_point
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // goal_index, heading_error, steer_cmd, speed_cmd, pad
    input  logic [0:0]  m_axis_tuser,   // no_path
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]  goal;
        logic [14:0] herr;
        logic [13:0] steer;
        logic [15:0] scmd;
        logic        no_path;
    } t_steer_result;

    logic signed [31:0] track_x [ppt_pkg::PATH_DEPTH];
    logic signed [31:0] track_y [ppt_pkg::PATH_DEPTH];
    int unsigned        track_len;
    int unsigned        goal_floor;
    logic [15:0]        gain_q88;
    logic [23:0]        base_q16;
    logic [15:0]        cruise_q88;
    t_steer_result      steer_queue[$];

    assign o_pending = steer_queue.size();

    function automatic logic [65:0] dist_squared(longint dx, longint dy);
        logic [65:0] mx, my;
        mx = (dx < 0) ? 66'(-dx) : 66'(dx);
        my = (dy < 0) ? 66'(-dy) : 66'(dy);
        return mx * mx + my * my;
    endfunction

    function automatic longint floor_root(logic [65:0] v);
        logic [69:0] rem, trial;
        logic [35:0] root;
        rem = '0;
        root = '0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 70'(v[2*k +: 2]);
            trial = 70'((root << 2) | 36'd1);
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 36'd1;
            end else begin
                root = root << 1;
            end
        end
        return longint'(root);
    endfunction

    function automatic longint bearing_q12(longint y, longint x);
        longint ang, t, nx, ny;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = ppt_pkg::HALF_PI_Q20;
            end else begin
                t = x; x = -y; y = t; ang = -ppt_pkg::HALF_PI_Q20;
            end
        end
        while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < ppt_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                ang += longint'(ppt_pkg::atan_q20(5'(i)));
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                ang -= longint'(ppt_pkg::atan_q20(5'(i)));
            end
            x = nx;
            y = ny;
        end
        return (ang + 128) >>> 8;
    endfunction

    function automatic t_steer_result pursue(longint px, longint py, longint yaw,
                                             longint spd);
        t_steer_result r;
        logic [65:0] best, d;
        int unsigned idx;
        longint reach, walked, alpha, steer, mag_a, scmd;
        r = '0;
        if (track_len == 0) begin
            r.no_path = 1'b1;
            return r;
        end
        idx = 0;
        best = dist_squared(px - track_x[0], py - track_y[0]);
        for (int unsigned i = 1; i < track_len; i++) begin
            d = dist_squared(px - track_x[i], py - track_y[i]);
            if (d < best) begin
                best = d;
                idx = i;
            end
        end
        reach = longint'(gain_q88) * spd + longint'(base_q16);
        walked = 0;
        while (walked < reach && idx + 1 < track_len) begin
            walked += floor_root(dist_squared(longint'(track_x[idx+1]) - track_x[idx],
                                              longint'(track_y[idx+1]) - track_y[idx]));
            idx++;
        end
        if (idx < goal_floor) idx = goal_floor;
        if (idx > track_len - 1) idx = track_len - 1;
        goal_floor = idx;
        alpha = bearing_q12(longint'(track_y[idx]) - py, longint'(track_x[idx]) - px) - yaw;
        if (alpha < -ppt_pkg::WRAP_LIMIT) alpha += ppt_pkg::WRAP_STEP;
        if (alpha > ppt_pkg::WRAP_LIMIT) alpha -= ppt_pkg::WRAP_STEP;
        steer = alpha;
        if (steer > ppt_pkg::STEER_LIMIT) steer = ppt_pkg::STEER_LIMIT;
        if (steer < -ppt_pkg::STEER_LIMIT) steer = -ppt_pkg::STEER_LIMIT;
        mag_a = alpha < 0 ? -alpha : alpha;
        if (mag_a == 0) begin
            scmd = 65535;
        end else begin
            scmd = (longint'(cruise_q88) * 4096) / mag_a;
            if (scmd > 65535) scmd = 65535;
        end
        r.goal = 8'(idx);
        r.herr = 15'(alpha);
        r.steer = 14'(steer);
        r.scmd = 16'(scmd);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_steer_result got, want;
        if (!i_rst_n) begin
            track_len <= 0;
            goal_floor <= 0;
            gain_q88 <= 16'd256;
            base_q16 <= 24'd65536;
            cruise_q88 <= 16'd256;
            steer_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    ppt_pkg::REG_GAIN:   gain_q88 <= pwdata[15:0];
                    ppt_pkg::REG_BASE:   base_q16 <= pwdata[23:0];
                    ppt_pkg::REG_TARGET: cruise_q88 <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (!s_axis_tuser[0]) begin
                    if (s_axis_tuser[1]) begin
                        track_len = 0;
                        goal_floor = 0;
                    end
                    if (track_len < ppt_pkg::PATH_DEPTH) begin
                        track_x[track_len] = s_axis_tdata[31:0];
                        track_y[track_len] = s_axis_tdata[63:32];
                        track_len++;
                    end
                end else begin
                    steer_queue.insert(steer_queue.size(), pursue(
                        longint'($signed(s_axis_tdata[31:0])),
                        longint'($signed(s_axis_tdata[63:32])),
                        longint'($signed(s_axis_tdata[78:64])),
                        longint'(s_axis_tdata[94:79])));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.goal = m_axis_tdata[7:0];
                got.herr = m_axis_tdata[22:8];
                got.steer = m_axis_tdata[36:23];
                got.scmd = m_axis_tdata[52:37];
                got.no_path = m_axis_tuser[0];
                if (steer_queue.size() == 0) begin
                    $display("%0t: unexpected result goal=%0d herr=%0d steer=%0d speed=%0d np=%0b",
                             $time, got.goal, $signed(got.herr), $signed(got.steer),
                             got.scmd, got.no_path);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = steer_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected goal=%0d herr=%0d steer=%0d speed=%0d np=%0b",
                                 $time, want.goal, $signed(want.herr), $signed(want.steer),
                                 want.scmd, want.no_path);
                        $display("%0t:          actual goal=%0d herr=%0d steer=%0d speed=%0d np=%0b",
                                 $time, got.goal, $signed(got.herr), $signed(got.steer),
                                 got.scmd, got.no_path);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/pure_pursuit_tracker_tb.sv =====
module pure_pursuit_tracker_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // pos_x, pos_y, yaw, speed, zero pad
    logic [1:0]  s_axis_tuser;   // req_type, first_point
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // goal_index, heading_error, steer_cmd, speed_cmd, pad
    logic [0:0]  m_axis_tuser;   // no_path
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          sink_idle;
    int          sent;
    logic signed [31:0] walk_x;
    logic signed [31:0] walk_y;

    pure_pursuit_tracker dut (.*);

    pure_pursuit_tracker_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("pure_pursuit_tracker verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    task automatic send_item(bit query, bit first, logic [31:0] x, logic [31:0] y,
                             int yaw, logic [15:0] spd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = {first, query};
        s_axis_tdata = {1'b0, spd, 15'(yaw), y, x};
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic load_point(bit first, logic [31:0] x, logic [31:0] y);
        send_item(1'b0, first, x, y, $urandom_range(25736) - 12868, 16'($urandom));
    endtask

    task automatic query(logic [31:0] x, logic [31:0] y, int yaw, logic [15:0] spd);
        send_item(1'b1, 1'($urandom), x, y, yaw, spd);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(logic [15:0] gain, logic [23:0] base, logic [15:0] target);
        settle();
        write_reg(ppt_pkg::REG_GAIN, {16'd0, gain});
        write_reg(ppt_pkg::REG_BASE, {8'd0, base});
        write_reg(ppt_pkg::REG_TARGET, {16'd0, target});
    endtask

    initial begin
        int len;
        int step;
        int phase;
        bit wide;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 14;
        sink_idle = 85;
        sent = 0;
        phase = 0;
        walk_x = '0;
        walk_y = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        query(32'd0, 32'd0, 0, 16'd0);
        send_item(1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 12868, 16'hffff);
        load_point(1'b1, 32'd0, 32'd0);
        query(32'd0, 32'd0, 0, 16'd0);
        query(32'd0, 32'd0, 12868, 16'd100);
        query(32'd0, 32'd0, -12868, 16'hffff);
        load_point(1'b1, 32'h8000_0000, 32'h8000_0000);
        load_point(1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
        load_point(1'b0, 32'h7fff_ffff, 32'h8000_0000);
        query(32'h7fff_ffff, 32'h8000_0000, -12868, 16'hffff);
        query(32'h8000_0000, 32'h7fff_ffff, 12868, 16'd0);
        query(32'h0001_0000, 32'hffff_0000, 0, 16'd0);

        configure(16'd0, 24'd0, 16'hffff);
        query(32'h8000_0000, 32'h8000_0000, 0, 16'hffff);
        query(32'h0000_8000, 32'h0000_8000, 3000, 16'd512);
        configure(16'hffff, 24'hff_ffff, 16'd0);
        query(32'h8000_0000, 32'h8000_0000, 0, 16'hffff);
        query(32'h0, 32'h0, -5000, 16'd1);
        configure(16'd256, 24'd65536, 16'd256);

        for (int i = 0; i < ppt_pkg::PATH_DEPTH + 4; i++)
            load_point(i == 0, 32'(i * 40000), 32'(i * 17000 - 2000000));
        query(32'd0, 32'hffe0_0000, 0, 16'd300);
        query(32'd5000000, 32'd0, 2000, 16'hffff);

        while (sent < 580) begin
            if (phase == 0 && sent >= 330) begin
                configure(16'($urandom), 24'($urandom), 16'($urandom));
                send_idle = 85;
                sink_idle = 14;
                phase = 1;
            end else if (phase == 1 && sent >= 455) begin
                configure(16'($urandom_range(1024)), 24'($urandom_range(1 << 20)),
                          16'($urandom));
                send_idle = 0;
                sink_idle = 0;
                phase = 2;
            end
            case ($urandom_range(9))
                0, 1, 2: begin
                    len = $urandom_range(1, 10);
                    wide = ($urandom_range(99) < 15);
                    walk_x = $urandom;
                    walk_y = $urandom;
                    for (int i = 0; i < len; i++) begin
                        load_point(i == 0, walk_x, walk_y);
                        if (wide) begin
                            walk_x = $urandom;
                            walk_y = $urandom;
                        end else begin
                            step = $urandom_range(1 << 18);
                            walk_x = walk_x + step - (1 << 16);
                            walk_y = walk_y + $urandom_range(1 << 18) - (1 << 17);
                        end
                    end
                end
                3: load_point(1'b0, walk_x + $urandom_range(1 << 17), walk_y);
                default: begin
                    query(walk_x - $urandom_range(1 << 19), walk_y + $urandom_range(1 << 18)
                          - (1 << 17), $urandom_range(25736) - 12868,
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600)));
                end
            endcase
        end

        settle();
        if (fail_count == 0) begin
            $display("pure_pursuit_tracker verification clean");
        end else begin
            $display("pure_pursuit_tracker verification failed");
        end
        $finish;
    end

endmodule
